// ===== design/page_framebuffer_draw_engine_defines.svh =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_defines
// assertion macros used by the checker file pfde_checker
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication
`define PFDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// types, opcodes and glyph shapes of the framebuffer draw engine
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PIXEL = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_RECT  = 3'd3;
    localparam logic [2:0] OP_GLYPH = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // coordinate width: 9-bit inputs plus rectangle and glyph extents
    localparam int CW = 11;
    // bresenham error term width
    localparam int EW = 13;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] err_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_pix;
        logic wr_pix;
        logic line_step;
        logic rect_init;
        logic rect_step;
        logic glyph_next;
        logic rd_byte;
        logic cap_byte;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       line_done;
        logic       rect_empty;
        logic       rect_last;
        logic       glyph_bit;
        logic       glyph_last;
        logic       out_free;
        logic [2:0] mode;
    } stat_t;

    function automatic logic [14:0] rows(input logic [2:0] r0, input logic [2:0] r1,
                                         input logic [2:0] r2, input logic [2:0] r3,
                                         input logic [2:0] r4);
        return {r0, r1, r2, r3, r4};
    endfunction

    // 3x5 shape, top row in the high bits, left column in the high bit of a row
    function automatic logic [14:0] glyph_shape(input logic [7:0] code);
        logic [7:0]  c;
        logic [14:0] s;
        c = (code >= 8'h61 && code <= 8'h7A) ? code - 8'd32 : code;
        unique case (c)
            8'h30: s = rows(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            8'h31: s = rows(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
            8'h32: s = rows(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
            8'h33: s = rows(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
            8'h34: s = rows(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
            8'h35: s = rows(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
            8'h36: s = rows(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
            8'h37: s = rows(3'd7, 3'd1, 3'd1, 3'd1, 3'd1);
            8'h38: s = rows(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
            8'h39: s = rows(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
            8'h41: s = rows(3'd7, 3'd5, 3'd7, 3'd5, 3'd5);
            8'h42: s = rows(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
            8'h43: s = rows(3'd7, 3'd4, 3'd4, 3'd4, 3'd7);
            8'h44: s = rows(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
            8'h45: s = rows(3'd7, 3'd4, 3'd7, 3'd4, 3'd7);
            8'h46: s = rows(3'd7, 3'd4, 3'd7, 3'd4, 3'd4);
            8'h47: s = rows(3'd7, 3'd4, 3'd5, 3'd5, 3'd7);
            8'h48: s = rows(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
            8'h49: s = rows(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
            8'h4A: s = rows(3'd1, 3'd1, 3'd1, 3'd5, 3'd7);
            8'h4B: s = rows(3'd5, 3'd5, 3'd6, 3'd5, 3'd5);
            8'h4C: s = rows(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
            8'h4D: s = rows(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
            8'h4E: s = rows(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
            8'h4F: s = rows(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            8'h50: s = rows(3'd7, 3'd5, 3'd7, 3'd4, 3'd4);
            8'h51: s = rows(3'd7, 3'd5, 3'd5, 3'd7, 3'd1);
            8'h52: s = rows(3'd7, 3'd5, 3'd7, 3'd6, 3'd5);
            8'h53: s = rows(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
            8'h54: s = rows(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
            8'h55: s = rows(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
            8'h56: s = rows(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
            8'h57: s = rows(3'd5, 3'd5, 3'd7, 3'd7, 3'd5);
            8'h58: s = rows(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
            8'h59: s = rows(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
            8'h5A: s = rows(3'd7, 3'd1, 3'd2, 3'd4, 3'd7);
            8'h3A: s = rows(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
            8'h2E: s = rows(3'd0, 3'd0, 3'd0, 3'd0, 3'd2);
            8'h2D: s = rows(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== design/pfde_if.sv =====
// ----------------------------------------------------------------------------
// pfde_if
// command and result channels of the framebuffer draw engine
// ----------------------------------------------------------------------------
interface pfde_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic signed [8:0] x_start;
    logic signed [8:0] y_start;
    logic signed [8:0] x_end;
    logic signed [8:0] y_end;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic              pixel_on;
    logic [7:0]        char_code;
    logic [3:0]        glyph_scale;
    logic [9:0]        byte_index;

    modport source (output valid, opcode, x_start, y_start, x_end, y_end, rect_width,
                    rect_height, pixel_on, char_code, glyph_scale, byte_index,
                    input ready);
    modport sink (input valid, opcode, x_start, y_start, x_end, y_end, rect_width,
                  rect_height, pixel_on, char_code, glyph_scale, byte_index,
                  output ready);
endinterface

interface pfde_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [2:0] done_opcode;

    modport source (output valid, read_data, done_opcode, input ready);
    modport sink (input valid, read_data, done_opcode, output ready);
endinterface

// ===== design/page_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// monochrome page-layout framebuffer with clear, pixel, line, rectangle,
// scaled glyph and byte read commands
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// --------+-----+---------------------------------------------------------
// cmd     | in  | opcode, coordinates, rect size, pixel_on, char, scale, index
// res     | out | read_data, done_opcode
//
// one command at a time; each pixel is one read-modify-write of the frame store,
// a read state then a write state, over each point of a line, each of the w*h
// pixels of a rectangle and a scale*scale box per lit glyph dot; a read fetches
// one byte, clear sweeps the store; after reset the store is swept to zero,
// all STORE bytes (1024 at 128x64), before the first command beat is taken
// the result register frees the engine: a new command is taken while the
// previous result waits; completion stalls only if that result is still held
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    pfde_cmd_if.sink   cmd,
    pfde_res_if.source res
);
    import pfde_pkg::*;

    cmd_t  ctl;
    stat_t st;

    // sequencer: walks each command through its pixel loop
    pfde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_opcode (cmd.opcode),
        .in_ready  (cmd.ready),
        .st        (st),
        .ctl       (ctl)
    );

    // datapath: frame store and the coordinate engines
    pfde_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st          (st),
        .opcode      (cmd.opcode),
        .x_start     (cmd.x_start),
        .y_start     (cmd.y_start),
        .x_end       (cmd.x_end),
        .y_end       (cmd.y_end),
        .rect_width  (cmd.rect_width),
        .rect_height (cmd.rect_height),
        .pixel_on    (cmd.pixel_on),
        .char_code   (cmd.char_code),
        .glyph_scale (cmd.glyph_scale),
        .byte_index  (cmd.byte_index),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .read_data   (res.read_data),
        .done_opcode (res.done_opcode)
    );

endmodule

// ===== design/pfde_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfde_ctrl
// command sequencer: steps clear, plot, line, rectangle, glyph and read
// ----------------------------------------------------------------------------
module pfde_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [2:0]    in_opcode,
    output logic          in_ready,
    input  pfde_pkg::stat_t st,
    output pfde_pkg::cmd_t  ctl
);
    import pfde_pkg::*;

    localparam logic [3:0] S_BOOT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PWR   = 4'd4;
    localparam logic [3:0] S_RINIT = 4'd5;
    localparam logic [3:0] S_GCHK  = 4'd6;
    localparam logic [3:0] S_GNEXT = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_RCAP  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_BOOT:
            begin
                ctl.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (in_opcode)
                        OP_CLEAR: state_next = S_CLR;
                        OP_PIXEL: state_next = S_PRD;
                        OP_LINE:  state_next = S_PRD;
                        OP_RECT:  state_next = S_RINIT;
                        OP_GLYPH: state_next = S_GCHK;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_FIN;
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = S_FIN;
            end
            S_PRD:
            begin
                ctl.rd_pix = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                ctl.wr_pix = 1'b1;
                unique case (st.mode)
                    OP_LINE:
                    begin
                        if (st.line_done)
                            state_next = S_FIN;
                        else
                        begin
                            ctl.line_step = 1'b1;
                            state_next    = S_PRD;
                        end
                    end
                    OP_RECT:
                    begin
                        ctl.rect_step = 1'b1;
                        state_next    = st.rect_last ? S_FIN : S_PRD;
                    end
                    OP_GLYPH:
                    begin
                        ctl.rect_step = 1'b1;
                        state_next    = st.rect_last ? S_GNEXT : S_PRD;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_RINIT:
            begin
                ctl.rect_init = 1'b1;
                state_next    = st.rect_empty ? S_FIN : S_PRD;
            end
            S_GCHK:
            begin
                if (st.glyph_bit && !st.rect_empty)
                begin
                    ctl.rect_init = 1'b1;
                    state_next    = S_PRD;
                end
                else
                    state_next = S_GNEXT;
            end
            S_GNEXT:
            begin
                if (st.glyph_last)
                    state_next = S_FIN;
                else
                begin
                    ctl.glyph_next = 1'b1;
                    state_next     = S_GCHK;
                end
            end
            S_READ:
            begin
                ctl.rd_byte = 1'b1;
                state_next  = S_RCAP;
            end
            S_RCAP:
            begin
                ctl.cap_byte = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_BOOT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/pfde_dp.sv =====
// ----------------------------------------------------------------------------
// pfde_dp
// datapath: frame store, line stepper, rectangle scan, glyph walk, result reg
// ----------------------------------------------------------------------------
module pfde_dp #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfde_pkg::cmd_t    ctl,
    output pfde_pkg::stat_t   st,
    input  logic [2:0]        opcode,
    input  logic signed [8:0] x_start,
    input  logic signed [8:0] y_start,
    input  logic signed [8:0] x_end,
    input  logic signed [8:0] y_end,
    input  logic [7:0]        rect_width,
    input  logic [7:0]        rect_height,
    input  logic              pixel_on,
    input  logic [7:0]        char_code,
    input  logic [3:0]        glyph_scale,
    input  logic [9:0]        byte_index,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        read_data,
    output logic [2:0]        done_opcode
);
    import pfde_pkg::*;

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE = SCREEN_WIDTH * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam coord_t XLIM = coord_t'(SCREEN_WIDTH);
    localparam coord_t YLIM = coord_t'(SCREEN_HEIGHT);

    // latched command
    logic [2:0] mode_reg;
    coord_t     xs_reg, ys_reg;
    logic [7:0] w_reg, h_reg;
    logic       on_reg;
    logic [3:0] scale_reg;
    logic [9:0] bidx_reg;

    // line stepper
    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    err_t   dx_reg, dy_reg, err_reg;
    logic   sxn_reg, syn_reg;

    // rectangle scan
    coord_t rc_reg, rr_reg, x0_reg, xend_reg, yend_reg;

    // glyph walk
    coord_t      gx_reg, gy_reg, gx0_reg;
    logic [1:0]  gcol_reg;
    logic [2:0]  grow_reg;
    logic [14:0] shape_reg;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg;
    logic [2:0]    out_op_reg;
    logic [7:0]    rdata_reg;

    logic [7:0]    mem [STORE];
    logic [7:0]    mem_q;

    // line setup from the incoming item
    coord_t in_xs, in_ys, in_xe, in_ye;
    err_t   in_dx, in_dy;
    assign in_xs = CW'(x_start);
    assign in_ys = CW'(y_start);
    assign in_xe = CW'(x_end);
    assign in_ye = CW'(y_end);
    assign in_dx = (in_xe > in_xs) ? EW'(in_xe - in_xs) : EW'(in_xs - in_xe);
    assign in_dy = (in_ye > in_ys) ? EW'(in_ys - in_ye) : EW'(in_ye - in_ys);

    // line step
    err_t   e2, err_n;
    logic   step_x, step_y;
    coord_t ax_n, ay_n;
    always_comb
    begin
        e2     = err_reg <<< 1;
        step_x = (e2 >= dy_reg);
        step_y = (e2 <= dx_reg);
        err_n  = err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);
        ax_n   = ax_reg;
        ay_n   = ay_reg;
        if (step_x)
            ax_n = sxn_reg ? ax_reg - coord_t'(1) : ax_reg + coord_t'(1);
        if (step_y)
            ay_n = syn_reg ? ay_reg - coord_t'(1) : ay_reg + coord_t'(1);
    end

    // rectangle source and scan
    coord_t src_x, src_y, src_w, src_h, rc_inc, rr_inc;
    logic   row_end;
    always_comb
    begin
        if (mode_reg == OP_RECT)
        begin
            src_x = xs_reg;
            src_y = ys_reg;
            src_w = CW'(w_reg);
            src_h = CW'(h_reg);
        end
        else
        begin
            src_x = gx_reg;
            src_y = gy_reg;
            src_w = CW'(scale_reg);
            src_h = CW'(scale_reg);
        end
    end
    assign rc_inc  = rc_reg + coord_t'(1);
    assign rr_inc  = rr_reg + coord_t'(1);
    assign row_end = (rc_inc == xend_reg);

    // current pixel
    coord_t        px, py;
    logic          pon, inb;
    logic [31:0]   pix_full;
    logic [AW-1:0] pix_addr;
    logic [7:0]    pix_mask, pix_wdata;
    always_comb
    begin
        case (mode_reg)
            OP_PIXEL:
            begin
                px  = xs_reg;
                py  = ys_reg;
                pon = on_reg;
            end
            OP_LINE:
            begin
                px  = ax_reg;
                py  = ay_reg;
                pon = 1'b1;
            end
            default:
            begin
                px  = rc_reg;
                py  = rr_reg;
                pon = 1'b1;
            end
        endcase
    end
    assign inb      = (px >= 0) && (px < XLIM) && (py >= 0) && (py < YLIM);
    assign pix_full = 32'(unsigned'(px)) + 32'(unsigned'(py) >> 3) * 32'(SCREEN_WIDTH);
    assign pix_addr = pix_full[AW-1:0];
    assign pix_mask = 8'b1 << py[2:0];
    assign pix_wdata = pon ? (mem_q | pix_mask) : (mem_q & ~pix_mask);

    // byte read
    logic          byte_oob;
    logic [AW-1:0] byte_addr;
    assign byte_oob  = (32'(bidx_reg) >= 32'(STORE));
    assign byte_addr = AW'(bidx_reg);

    // frame store
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [7:0]    wdata;
    assign raddr = ctl.rd_byte ? byte_addr : pix_addr;
    assign waddr = ctl.clr_wr ? clr_addr_reg : pix_addr;
    assign we    = ctl.clr_wr || (ctl.wr_pix && inb);
    assign wdata = ctl.clr_wr ? 8'd0 : pix_wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (ctl.rd_pix || ctl.rd_byte)
            mem_q <= mem[raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mode_reg  <= opcode;
            xs_reg    <= in_xs;
            ys_reg    <= in_ys;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            on_reg    <= pixel_on;
            scale_reg <= glyph_scale;
            bidx_reg  <= byte_index;
            ax_reg    <= in_xs;
            ay_reg    <= in_ys;
            bx_reg    <= in_xe;
            by_reg    <= in_ye;
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
            err_reg   <= in_dx + in_dy;
            sxn_reg   <= !(in_xs < in_xe);
            syn_reg   <= !(in_ys < in_ye);
            gx_reg    <= in_xs;
            gy_reg    <= in_ys;
            gx0_reg   <= in_xs;
            gcol_reg  <= 2'd0;
            grow_reg  <= 3'd0;
            shape_reg <= glyph_shape(char_code);
        end
        if (ctl.line_step)
        begin
            err_reg <= err_n;
            ax_reg  <= ax_n;
            ay_reg  <= ay_n;
        end
        if (ctl.rect_init)
        begin
            rc_reg   <= src_x;
            rr_reg   <= src_y;
            x0_reg   <= src_x;
            xend_reg <= src_x + src_w;
            yend_reg <= src_y + src_h;
        end
        if (ctl.rect_step)
        begin
            if (row_end)
            begin
                rc_reg <= x0_reg;
                rr_reg <= rr_inc;
            end
            else
                rc_reg <= rc_inc;
        end
        if (ctl.glyph_next)
        begin
            shape_reg <= shape_reg << 1;
            if (gcol_reg == 2'd2)
            begin
                gcol_reg <= 2'd0;
                grow_reg <= grow_reg + 3'd1;
                gx_reg   <= gx0_reg;
                gy_reg   <= gy_reg + CW'(scale_reg);
            end
            else
            begin
                gcol_reg <= gcol_reg + 2'd1;
                gx_reg   <= gx_reg + CW'(scale_reg);
            end
        end
        if (ctl.cap_byte)
            rdata_reg <= byte_oob ? 8'd0 : mem_q;
        if (ctl.res_load)
        begin
            out_data_reg <= (mode_reg == OP_READ) ? rdata_reg : 8'd0;
            out_op_reg   <= mode_reg;
        end
    end

    // control registers
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (ctl.clr_wr)
            clr_addr_next = st.clr_last ? '0 : clr_addr_reg + AW'(1);
        out_valid_next = out_valid_reg;
        if (ctl.res_load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign st.clr_last   = (32'(clr_addr_reg) == 32'(STORE - 1));
    assign st.line_done  = (ax_reg == bx_reg) && (ay_reg == by_reg);
    assign st.rect_empty = (src_w == 0) || (src_h == 0);
    assign st.rect_last  = row_end && (rr_inc == yend_reg);
    assign st.glyph_bit  = shape_reg[14];
    assign st.glyph_last = (grow_reg == 3'd4) && (gcol_reg == 2'd2);
    assign st.out_free   = !out_valid_reg || res_ready;
    assign st.mode       = mode_reg;

    assign res_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign done_opcode = out_op_reg;

endmodule

// ===== design/pfde_checker.sv =====
// ----------------------------------------------------------------------------
// pfde_checker
// port-level checks of the framebuffer draw engine, bound to the top level
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_defines.svh"

module pfde_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] read_data,
    input logic [2:0] done_opcode
);
    import pfde_pkg::*;

    // result beat held until taken
    `PFDE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // held result keeps its payload
    `PFDE_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(read_data) && $stable(done_opcode), "stalled result changed")

    // only a read returns data
    `PFDE_ASSERT_NOW(a_data_zero, clk, rst_n, res_valid && done_opcode != OP_READ, read_data == 8'd0, "nonzero data on a non-read result")

    // engine busy after taking a command
    `PFDE_ASSERT_NEXT(a_busy, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "second command taken back to back")

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .read_data   (res.read_data),
    .done_opcode (res.done_opcode)
);

// ===== verif/pfde_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_frame_checker
// watches the command and result channels of the draw engine, keeps its own
// copy of the frame store, predicts each result and compares it in order
// ----------------------------------------------------------------------------
module pfde_frame_checker (
    input  logic clk,
    input  logic rst_n,
    pfde_cmd_if  cmd,
    pfde_res_if  res,
    output int   fail_count,
    output int   pending,
    output int   results_seen
);
    import pfde_pkg::*;

    localparam int WIDTH  = 128;
    localparam int HEIGHT = 64;
    localparam int BYTES  = WIDTH * ((HEIGHT + 7) / 8);

    typedef struct {
        logic [7:0] read_data;
        logic [2:0] done_opcode;
    } outcome_t;

    // 3x5 shapes, five octal digits top row first, left column in the high bit
    localparam logic [14:0] DIGIT_SHAPES [10] = '{
        15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
        15'o74717, 15'o74757, 15'o71111, 15'o75757, 15'o75717
    };
    localparam logic [14:0] ALPHA_SHAPES [26] = '{
        15'o75755, 15'o65656, 15'o74447, 15'o65556, 15'o74747, 15'o74744,
        15'o74557, 15'o55755, 15'o72227, 15'o11157, 15'o55655, 15'o44447,
        15'o57755, 15'o57775, 15'o75557, 15'o75744, 15'o75571, 15'o75765,
        15'o74717, 15'o72222, 15'o55557, 15'o55552, 15'o55775, 15'o55255,
        15'o55222, 15'o71247
    };

    logic [7:0] frame_img [BYTES];
    outcome_t   outcome_q [$];

    function automatic logic [14:0] glyph_bits(input logic [7:0] code);
        logic [7:0] c;
        c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
        if (c >= "0" && c <= "9") return DIGIT_SHAPES[c - "0"];
        if (c >= "A" && c <= "Z") return ALPHA_SHAPES[c - "A"];
        if (c == ":") return 15'o02020;
        if (c == ".") return 15'o00002;
        if (c == "-") return 15'o00700;
        return '0;
    endfunction

    function automatic void put_pixel(input int x, input int y, input bit on);
        int idx;
        if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT)
            return;
        idx = x + (y / 8) * WIDTH;
        frame_img[idx][y % 8] = on;
    endfunction

    function automatic void fill_box(input int x, input int y, input int w, input int h);
        for (int r = y; r < y + h; r++)
            for (int c = x; c < x + w; c++)
                put_pixel(c, r, 1'b1);
    endfunction

    function automatic void trace_line(input int ax, input int ay, input int bx,
                                       input int by);
        int dx, dy, sx, sy, err, e2;
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = -((by > ay) ? by - ay : ay - by);
        sx = (ax < bx) ? 1 : -1;
        sy = (ay < by) ? 1 : -1;
        err = dx + dy;
        forever
        begin
            put_pixel(ax, ay, 1'b1);
            if (ax == bx && ay == by)
                break;
            e2 = 2 * err;
            if (e2 >= dy)
            begin
                err += dy;
                ax += sx;
            end
            if (e2 <= dx)
            begin
                err += dx;
                ay += sy;
            end
        end
    endfunction

    function automatic void stamp_glyph(input int x, input int y, input logic [7:0] code,
                                        input int scale);
        logic [14:0] bits;
        bits = glyph_bits(code);
        for (int row = 0; row < 5; row++)
            for (int col = 0; col < 3; col++)
                if (bits[14 - (row * 3 + col)])
                    fill_box(x + col * scale, y + row * scale, scale, scale);
    endfunction

    // applies one command to the frame copy and returns the result it must give
    function automatic outcome_t apply_command();
        outcome_t o;
        o.read_data   = '0;
        o.done_opcode = cmd.opcode;
        case (cmd.opcode)
            OP_CLEAR: foreach (frame_img[i]) frame_img[i] = '0;
            OP_PIXEL: put_pixel(cmd.x_start, cmd.y_start, cmd.pixel_on);
            OP_LINE:  trace_line(cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end);
            OP_RECT:  fill_box(cmd.x_start, cmd.y_start, cmd.rect_width, cmd.rect_height);
            OP_GLYPH: stamp_glyph(cmd.x_start, cmd.y_start, cmd.char_code,
                                  cmd.glyph_scale);
            OP_READ:  if (cmd.byte_index < BYTES) o.read_data = frame_img[cmd.byte_index];
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            foreach (frame_img[i]) frame_img[i] = '0;
            outcome_q.delete();
            fail_count    = 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                results_seen <= results_seen + 1;
                if (outcome_q.size() == 0)
                    report("result beat with nothing expected, opcode", res.done_opcode, 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (res.done_opcode !== want.done_opcode)
                        report("done_opcode", res.done_opcode, want.done_opcode);
                    if (res.read_data !== want.read_data)
                        report("read_data", res.read_data, want.read_data);
                end
            end
            if (cmd.valid && cmd.ready)
                outcome_q.push_back(apply_command());
            pending <= outcome_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives draw commands into the framebuffer engine with random gaps and result
// back-pressure; the frame checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_top;
    import pfde_pkg::*;

    typedef struct {
        logic [2:0]        opcode;
        logic signed [8:0] xs;
        logic signed [8:0] ys;
        logic signed [8:0] xe;
        logic signed [8:0] ye;
        logic [7:0]        w;
        logic [7:0]        h;
        logic              on;
        logic [7:0]        code;
        logic [3:0]        scale;
        logic [9:0]        index;
    } draw_cmd_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   op_count [8];
    int   cmds_sent;
    bit   hold_req;     // asks the result side for one long stall
    bit   gapless;      // sender runs back to back in this stretch

    pfde_cmd_if cmd ();
    pfde_res_if res ();

    page_framebuffer_draw_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    pfde_frame_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .res          (res),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop well past the slowest legal run (one huge rect of 255x255 pixels)
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // short random gap, now and then a long one, none in gapless stretches
    function automatic int pick_gap();
        if (gapless || $urandom_range(3, 0) != 0)
            return 0;
        if ($urandom_range(15, 0) == 0)
            return $urandom_range(80, 20);
        return $urandom_range(3, 1);
    endfunction

    // result side: random ready with a counted long hold-off on request
    initial
    begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                res.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                res.ready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // one beat on the command channel, optional idle cycles first
    task automatic send(input draw_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.opcode      <= c.opcode;
        cmd.x_start     <= c.xs;
        cmd.y_start     <= c.ys;
        cmd.x_end       <= c.xe;
        cmd.y_end       <= c.ye;
        cmd.rect_width  <= c.w;
        cmd.rect_height <= c.h;
        cmd.pixel_on    <= c.on;
        cmd.char_code   <= c.code;
        cmd.glyph_scale <= c.scale;
        cmd.byte_index  <= c.index;
        do
            @(posedge clk);
        while (!cmd.ready);
        op_count[c.opcode]++;
        cmds_sent++;
    endtask

    function automatic draw_cmd_t blank_cmd(input logic [2:0] op);
        draw_cmd_t c;
        c.opcode = op;
        c.xs = 9'($urandom);
        c.ys = 9'($urandom);
        c.xe = 9'($urandom);
        c.ye = 9'($urandom);
        c.w = 8'($urandom);
        c.h = 8'($urandom);
        c.on = 1'($urandom);
        c.code = 8'($urandom);
        c.scale = 4'($urandom);
        c.index = 10'($urandom);
        return c;
    endfunction

    function automatic draw_cmd_t make_cmd(input logic [2:0] op, input int xs,
                                           input int ys, input int xe, input int ye);
        draw_cmd_t c;
        c = blank_cmd(op);
        c.xs = 9'(xs);
        c.ys = 9'(ys);
        c.xe = 9'(xe);
        c.ye = 9'(ye);
        return c;
    endfunction

    // coordinate mostly near the screen, sometimes anywhere in 9 bits
    function automatic int near_coord(input int span);
        if ($urandom_range(9, 0) == 0)
            return $signed(9'($urandom));
        return $urandom_range(span + 12, 0) - 12;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int        pick;
        pick = $urandom_range(99, 0);
        if (pick < 2)       c = blank_cmd(OP_CLEAR);
        else if (pick < 22) c = blank_cmd(OP_PIXEL);
        else if (pick < 37) c = blank_cmd(OP_LINE);
        else if (pick < 49) c = blank_cmd(OP_RECT);
        else if (pick < 61) c = blank_cmd(OP_GLYPH);
        else if (pick < 97) c = blank_cmd(OP_READ);
        else                c = blank_cmd(3'($urandom_range(7, 6)));
        c.xs = 9'(near_coord(128));
        c.ys = 9'(near_coord(64));
        if ($urandom_range(1, 0) == 0)
        begin
            // short lines dominate, long ones still show up
            c.xe = 9'(c.xs + $urandom_range(40, 0) - 20);
            c.ye = 9'(c.ys + $urandom_range(40, 0) - 20);
        end
        else
        begin
            c.xe = 9'(near_coord(128));
            c.ye = 9'(near_coord(64));
        end
        // keep rectangle area small; a wide one stays flat and a tall one thin
        case ($urandom_range(9, 0))
            0: begin c.w = 8'($urandom); c.h = 8'($urandom_range(3, 0)); end
            1: begin c.w = 8'($urandom_range(3, 0)); c.h = 8'($urandom); end
            default: begin c.w = 8'($urandom_range(20, 0)); c.h = 8'($urandom_range(20, 0)); end
        endcase
        c.scale = ($urandom_range(7, 0) == 0) ? 4'($urandom) : 4'($urandom_range(4, 1));
        if ($urandom_range(1, 0) == 0)
            c.code = 8'($urandom_range(8'h7A, 8'h2D));
        // every read index falls inside the 1024-byte store
        c.index = ($urandom_range(3, 0) == 0) ? 10'($urandom) : 10'($urandom_range(1023, 0));
        return c;
    endfunction

    initial
    begin
        draw_cmd_t c;
        hold_req        = 1'b0;
        gapless         = 1'b0;
        cmds_sent       = 0;
        foreach (op_count[i]) op_count[i] = 0;
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.opcode      = '0;
        cmd.x_start     = '0;
        cmd.y_start     = '0;
        cmd.x_end       = '0;
        cmd.y_end       = '0;
        cmd.rect_width  = '0;
        cmd.rect_height = '0;
        cmd.pixel_on    = 1'b0;
        cmd.char_code   = '0;
        cmd.glyph_scale = '0;
        cmd.byte_index  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, off-screen drops, every opcode and glyph corner case
        c = make_cmd(OP_READ, 0, 0, 0, 0);       c.index = 0;       send(c);
        c = make_cmd(OP_PIXEL, 0, 0, 0, 0);      c.on = 1'b1;       send(c);
        c = make_cmd(OP_PIXEL, 127, 63, 0, 0);   c.on = 1'b1;       send(c);
        c = make_cmd(OP_PIXEL, 128, 0, 0, 0);    c.on = 1'b1;       send(c);
        c = make_cmd(OP_PIXEL, -256, 255, 0, 0); c.on = 1'b1;       send(c);
        c = make_cmd(OP_READ, 0, 0, 0, 0);       c.index = 0;       send(c);
        c = make_cmd(OP_READ, 0, 0, 0, 0);       c.index = 1023;    send(c);
        c = make_cmd(OP_PIXEL, 0, 0, 0, 0);      c.on = 1'b0;       send(c);
        c = make_cmd(OP_LINE, -256, -256, 255, 255);                send(c);
        c = make_cmd(OP_LINE, 5, 5, 5, 5);                          send(c);
        c = make_cmd(OP_LINE, 100, 63, 100, -1);                    send(c);
        c = make_cmd(OP_RECT, 10, 10, 0, 0);     c.w = 0; c.h = 9;  send(c);
        c = make_cmd(OP_RECT, -256, -256, 0, 0); c.w = 255; c.h = 255; send(c);
        c = make_cmd(OP_READ, 0, 0, 0, 0);       c.index = 517;     send(c);
        c = make_cmd(OP_CLEAR, 0, 0, 0, 0);                         send(c);
        c = make_cmd(OP_GLYPH, 0, 0, 0, 0);      c.code = "a"; c.scale = 0;  send(c);
        c = make_cmd(OP_GLYPH, 2, 1, 0, 0);      c.code = "a"; c.scale = 1;  send(c);
        c = make_cmd(OP_GLYPH, 10, 0, 0, 0);     c.code = "Z"; c.scale = 15; send(c);
        c = make_cmd(OP_GLYPH, 60, 8, 0, 0);     c.code = ":"; c.scale = 2;  send(c);
        c = make_cmd(OP_GLYPH, 70, 8, 0, 0);     c.code = "."; c.scale = 2;  send(c);
        c = make_cmd(OP_GLYPH, 80, 8, 0, 0);     c.code = "-"; c.scale = 2;  send(c);
        c = make_cmd(OP_GLYPH, 90, 8, 0, 0);     c.code = 8'hFF; c.scale = 3; send(c);
        send(blank_cmd(3'd6));
        send(blank_cmd(3'd7));
        c = make_cmd(OP_READ, 0, 0, 0, 0);       c.index = 2;       send(c);

        // random part with a gapless stretch, a receiver hold-off and a drain pause
        for (int n = 0; n < 2000; n++)
        begin
            gapless = (n >= 400 && n < 600);
            if (n == 800)
                hold_req = 1'b1;    // cheap pixels keep coming while the held result stalls the engine
            if (n == 1200)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            if (n >= 800 && n < 830)
                c = blank_cmd(OP_PIXEL);
            else
                c = random_cmd();
            send(c);
        end
        cmd.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("run: %0d commands, %0d result beats checked", cmds_sent, results_seen);
        $display("mix: clear %0d pixel %0d line %0d rect %0d glyph %0d read %0d unused %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5], op_count[6] + op_count[7]);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
